/* design/mbrrm_pkg.sv */
// Shared constants, register indexes and the decode record of the bank mapper.
package mbrrm_pkg;

  // Size of the cartridge RAM held inside the block; a power of two.
  localparam int unsigned XRAM_DEPTH    = 32768;
  localparam int unsigned RAM_AW        = $clog2(XRAM_DEPTH);
  localparam int unsigned ROM_ADDR_BITS = 21;

  localparam int unsigned ROM_AW       = 21;
  localparam int unsigned ROM_LEN_W    = 22;
  localparam int unsigned BANK_MASK_W  = 7;
  localparam int unsigned RAM_SEL_W    = 2;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [ROM_AW-1:0] ROM_ADDR_MASK = ROM_AW'((64'd1 << ROM_ADDR_BITS) - 64'd1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE  = 2'd2;

  localparam logic [ROM_LEN_W-1:0]   ROM_LEN_RST   = 22'h008000;
  localparam logic [BANK_MASK_W-1:0] BANK_MASK_RST = 7'h01;
  localparam logic [RAM_SEL_W-1:0]   RAM_SEL_RST   = 2'd0;

  localparam logic [7:0] OPEN_BUS = 8'hFF;

  // Everything the address decode hands to the pipeline for one bus access.
  typedef struct packed {
    logic              ram_en;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic              use_ram;
    logic [7:0]        rdata;
    logic              fetch;
    logic [ROM_AW-1:0] raddr;
  } dec_t;

endpackage

/* design/mode_banked_rom_ram_mapper_top.sv */
// Top level of the cartridge bank mapper: clearing pass, RAM and result pipeline.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | to block  | in_valid_i / in_ready_o   | func_i, addr_i, wdata_i
//  out     | from blk  | out_valid_o / out_ready_i | rdata_o, rom_fetch_o, rom_addr_o
//  cfg     | to block  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One bus access is accepted per cycle while in_ready_o is high; each result
// goes through the middle stage, with its registered RAM read, and then the
// output register. After reset the block zeroes all XRAM_DEPTH (32768) bytes of
// the cartridge RAM, one byte a cycle, with in_ready_o low; configuration writes
// are taken throughout. A stalled output holds the middle stage, and the input
// keeps flowing as long as the middle stage can move on.
module mode_banked_rom_ram_mapper_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  func_i,
  input  logic [15:0]                           addr_i,
  input  logic [7:0]                            wdata_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [7:0]                            rdata_o,
  output logic                                  rom_fetch_o,
  output logic [mbrrm_pkg::ROM_AW-1:0]          rom_addr_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mbrrm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mbrrm_pkg::ROM_LEN_W-1:0]       cfg_data_i
);
  import mbrrm_pkg::*;

  // Clearing pass: the counter walks every RAM address once, then its top bit
  // stays set and the block is open for bus accesses.
  logic [RAM_AW:0]   clr_cnt_q;
  logic              clearing;

  logic              accept;
  logic              advance;
  dec_t              dec;

  logic              ram_en;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  // Middle stage: the decode of an accepted access while its RAM read is out.
  logic              s1_valid_q;
  logic              s1_use_ram_q;
  logic [7:0]        s1_rdata_q;
  logic              s1_fetch_q;
  logic [ROM_AW-1:0] s1_raddr_q;

  logic              out_valid_q;
  logic [7:0]        out_rdata_q;
  logic              out_fetch_q;
  logic [ROM_AW-1:0] out_raddr_q;

  assign clearing = !clr_cnt_q[RAM_AW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clearing) begin
      clr_cnt_q <= clr_cnt_q + {{RAM_AW{1'b0}}, 1'b1};
    end
  end

  // The output register can take the middle stage when it is empty or drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !clearing && (!s1_valid_q || advance);
  assign accept     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  mbrrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (accept),
    .func_i      (func_i),
    .addr_i      (addr_i),
    .wdata_i     (wdata_i),
    .dec_o       (dec)
  );

  // A write commits at its own transfer edge, so a read accepted in the next
  // cycle already sees it; no forwarding is needed. The RAM read register only
  // loads on a read, so it holds its byte while the middle stage is stalled.
  assign ram_en    = clearing || (accept && dec.ram_en);
  assign ram_we    = clearing || dec.ram_we;
  assign ram_addr  = clearing ? clr_cnt_q[RAM_AW-1:0] : dec.ram_addr;
  assign ram_wdata = clearing ? 8'h00 : wdata_i;

  mbrrm_ram #(
    .WIDTH (8),
    .DEPTH (XRAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_use_ram_q <= dec.use_ram;
      s1_rdata_q   <= dec.rdata;
      s1_fetch_q   <= dec.fetch;
      s1_raddr_q   <= dec.raddr;
    end
    if (advance && s1_valid_q) begin
      out_rdata_q <= s1_use_ram_q ? ram_rdata : s1_rdata_q;
      out_fetch_q <= s1_fetch_q;
      out_raddr_q <= s1_raddr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rdata_o     = out_rdata_q;
  assign rom_fetch_o = out_fetch_q;
  assign rom_addr_o  = out_raddr_q;

endmodule

/* design/mbrrm_ram.sv */
// Generic single-port synchronous RAM with a registered read port.
module mbrrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A write leaves the read register untouched.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/mbrrm_ctrl.sv */
// Bank and configuration registers with the bus address decode.
module mbrrm_ctrl (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mbrrm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mbrrm_pkg::ROM_LEN_W-1:0]       cfg_data_i,
  input  logic                                  acc_i,
  input  logic                                  func_i,
  input  logic [15:0]                           addr_i,
  input  logic [7:0]                            wdata_i,
  output mbrrm_pkg::dec_t                       dec_o
);
  import mbrrm_pkg::*;

  localparam logic [2:0] RGN_RAM_ON   = 3'd0;
  localparam logic [2:0] RGN_LOW_BANK = 3'd1;
  localparam logic [2:0] RGN_HIGH     = 3'd2;
  localparam logic [2:0] RGN_MODE     = 3'd3;
  localparam logic [2:0] RGN_EXT_RAM  = 3'd5;

  logic [ROM_LEN_W-1:0]   rom_len_q;
  logic [BANK_MASK_W-1:0] bank_mask_q;
  logic [RAM_SEL_W-1:0]   ram_sel_q;
  logic [4:0]             low_bank_q, low_bank_d;
  logic [1:0]             high_q;
  logic                   mode_q;
  logic                   ram_on_q;

  logic [2:0]             region;
  logic                   ram_ok;
  logic [1:0]             xram_page;
  logic [14:0]            ram_idx;
  logic [6:0]             rom_page;
  logic [ROM_AW-1:0]      rom_off;
  logic                   in_rom;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_len_q   <= ROM_LEN_RST;
      bank_mask_q <= BANK_MASK_RST;
      ram_sel_q   <= RAM_SEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROM_LEN:   rom_len_q   <= cfg_data_i;
        CFG_BANK_MASK: bank_mask_q <= cfg_data_i[BANK_MASK_W-1:0];
        CFG_RAM_SIZE:  ram_sel_q   <= cfg_data_i[RAM_SEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign region     = addr_i[15:13];
  assign low_bank_d = (wdata_i[4:0] == 5'd0) ? 5'd1 : wdata_i[4:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_bank_q <= 5'd1;
      high_q     <= 2'd0;
      mode_q     <= 1'b0;
      ram_on_q   <= 1'b0;
    end else if (acc_i && func_i) begin
      unique case (region)
        RGN_RAM_ON:   ram_on_q   <= (wdata_i[3:0] == 4'hA);
        RGN_LOW_BANK: low_bank_q <= low_bank_d;
        RGN_HIGH:     high_q     <= wdata_i[1:0];
        RGN_MODE:     mode_q     <= wdata_i[0];
        default: ;
      endcase
    end
  end

  // RAM bank: the upper bits, reduced to the bank count, only in mode 1.
  always_comb begin
    case (ram_sel_q)
      2'd2:    xram_page = mode_q ? {1'b0, high_q[0]} : 2'd0;
      2'd3:    xram_page = mode_q ? high_q : 2'd0;
      default: xram_page = 2'd0;
    endcase
  end

  assign ram_ok  = ram_on_q && (ram_sel_q != 2'd0);
  assign ram_idx = {xram_page, addr_i[12:0]};

  // ROM translation: bank number in the top bits, slot offset below.
  assign rom_page = (addr_i[14] ? {high_q, low_bank_q} : (mode_q ? {high_q, 5'd0} : 7'd0))
                    & bank_mask_q;
  assign rom_off  = {rom_page, addr_i[13:0]};
  assign in_rom   = {1'b0, rom_off} < rom_len_q;

  always_comb begin
    dec_o          = '0;
    dec_o.ram_addr = ram_idx[RAM_AW-1:0];
    if (func_i) begin
      dec_o.ram_en = (region == RGN_EXT_RAM) && ram_ok;
      dec_o.ram_we = dec_o.ram_en;
    end else if (!addr_i[15]) begin
      if (in_rom) begin
        dec_o.fetch = 1'b1;
        dec_o.raddr = rom_off & ROM_ADDR_MASK;
      end else begin
        dec_o.rdata = OPEN_BUS;
      end
    end else if ((region == RGN_EXT_RAM) && ram_ok) begin
      dec_o.ram_en  = 1'b1;
      dec_o.use_ram = 1'b1;
    end else begin
      dec_o.rdata = OPEN_BUS;
    end
  end

endmodule
